### design/rde_pkg.sv
// Shared constants, types and helper functions for the signed radix digit emitter.
// Used by rde_config, rde_ctrl, rde_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rde_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_RADIX  = 16;
    localparam int CHAR_W     = 8;
    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int ALPHA_W    = MAX_RADIX * CHAR_W;
    localparam int HALF_W     = ALPHA_W / 2;
    localparam int DEPTH      = VALUE_BITS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HALF_W;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic rd;
        logic emit_err;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic q_zero;
        logic nd_zero;
        logic out_free;
    } sts_t;

    // floor(2^32 / r); the quotient estimate it gives is at most one below the truth.
    function automatic logic [VALUE_BITS-1:0] recip(input logic [RADIX_W-1:0] r);
        logic [VALUE_BITS-1:0] m;
        begin
            case (r)
                5'd2:    m = 32'h8000_0000;
                5'd3:    m = 32'h5555_5555;
                5'd4:    m = 32'h4000_0000;
                5'd5:    m = 32'h3333_3333;
                5'd6:    m = 32'h2AAA_AAAA;
                5'd7:    m = 32'h2492_4924;
                5'd8:    m = 32'h2000_0000;
                5'd9:    m = 32'h1C71_C71C;
                5'd10:   m = 32'h1999_9999;
                5'd11:   m = 32'h1745_D174;
                5'd12:   m = 32'h1555_5555;
                5'd13:   m = 32'h13B1_3B13;
                5'd14:   m = 32'h1249_2492;
                5'd15:   m = 32'h1111_1111;
                5'd16:   m = 32'h1000_0000;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [ALPHA_W-1:0] alpha,
                                                     input logic [DIGIT_W-1:0] d);
        return alpha[d*CHAR_W +: CHAR_W];
    endfunction

    function automatic logic alphabet_valid(input logic [RADIX_W-1:0] r,
                                            input logic [ALPHA_W-1:0] alpha);
        logic ok;
        logic [CHAR_W-1:0] ca;
        begin
            ok = (r >= RADIX_W'(2)) && (r <= RADIX_W'(MAX_RADIX));
            for (int a = 0; a < MAX_RADIX; a++) begin
                ca = alpha[a*CHAR_W +: CHAR_W];
                if (RADIX_W'(a) < r) begin
                    if ((ca == CHAR_PLUS) || (ca == CHAR_MINUS)) begin
                        ok = 1'b0;
                    end
                    for (int b = 0; b < a; b++) begin
                        if (alpha[b*CHAR_W +: CHAR_W] == ca) begin
                            ok = 1'b0;
                        end
                    end
                end
            end
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

### design/rde_config.sv
// Configuration registers (radix and alphabet) and the registered alphabet check.
// Depends on rde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rde_config (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [rde_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  wire logic [rde_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output logic      [rde_pkg::RADIX_W-1:0]       radix,
    output logic      [rde_pkg::ALPHA_W-1:0]       alphabet,
    output logic                                   alpha_ok
);

    logic [rde_pkg::RADIX_W-1:0] radix_reg;
    logic [rde_pkg::HALF_W-1:0]  alpha_low_reg;
    logic [rde_pkg::HALF_W-1:0]  alpha_high_reg;
    logic                        alpha_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= '0;
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            alpha_ok_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    rde_pkg::REG_RADIX:      radix_reg <= cfg_wr_data[rde_pkg::RADIX_W-1:0];
                    rde_pkg::REG_ALPHA_LOW:  alpha_low_reg <= cfg_wr_data;
                    rde_pkg::REG_ALPHA_HIGH: alpha_high_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            alpha_ok_reg <= rde_pkg::alphabet_valid(radix_reg,
                                                    {alpha_high_reg, alpha_low_reg});
        end
    end

    assign radix    = radix_reg;
    assign alphabet = {alpha_high_reg, alpha_low_reg};
    assign alpha_ok = alpha_ok_reg;

endmodule

`default_nettype wire

### design/rde_ctrl.sv
// Controller state machine: sequences load, digit division, and error, sign and digit emission.
// Depends on rde_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rde_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          alpha_ok,
    input  wire rde_pkg::sts_t sts,
    output rde_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;
    localparam logic [2:0] ST_SIGN  = 3'd5;
    localparam logic [2:0] ST_READ  = 3'd6;
    localparam logic [2:0] ST_POP   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = alpha_ok ? ST_MUL : ST_ERR;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (!sts.q_zero) begin
                    state_next = ST_MUL;
                end else if (sts.neg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_ERR: begin
                if (sts.out_free) begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SIGN: begin
                if (sts.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_POP;
            end
            ST_POP: begin
                if (sts.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (sts.nd_zero) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.rd = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/rde_datapath.sv
// Datapath: magnitude register, reciprocal divider step, digit stack and output register.
// Depends on rde_pkg; driven by rde_ctrl through the command struct.
`timescale 1ns / 1ps
`default_nettype none

module rde_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [rde_pkg::VALUE_BITS-1:0] value,
    input  wire logic [rde_pkg::RADIX_W-1:0]    radix,
    input  wire logic [rde_pkg::ALPHA_W-1:0]    alphabet,
    input  wire rde_pkg::cmd_t                  cmd,
    output rde_pkg::sts_t                       sts,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [rde_pkg::CHAR_W-1:0]     character,
    output logic                                last,
    output logic                                error
);

    localparam int VB = rde_pkg::VALUE_BITS;
    localparam int RW = rde_pkg::RADIX_W;

    logic [VB-1:0]                   mag_reg;
    logic                            neg_reg;
    logic [VB-1:0]                   recip_reg;
    logic [2*VB-1:0]                 prod_reg;
    logic [rde_pkg::CNT_W-1:0]       nd_reg;
    logic [rde_pkg::DIGIT_W-1:0]     stack_mem [0:rde_pkg::DEPTH-1];
    logic [rde_pkg::DIGIT_W-1:0]     rd_data_reg;
    logic                            m_tvalid_reg;
    logic [rde_pkg::CHAR_W-1:0]      char_reg;
    logic                            last_reg;
    logic                            error_reg;

    logic [VB-1:0]                   q0;
    logic [2*RW-1:0]                 qr_low;
    logic [RW-1:0]                   rem0;
    logic [RW-1:0]                   rem_adj;
    logic                            ge;
    logic [rde_pkg::DIGIT_W-1:0]     digit;
    logic [VB-1:0]                   q;
    logic [rde_pkg::CNT_W-1:0]       nd_dec;
    logic                            out_free;

    // The estimate is at most one short, so the remainder stays below twice the radix.
    assign q0      = prod_reg[2*VB-1:VB];
    assign qr_low  = {{RW{1'b0}}, q0[RW-1:0]} * {{RW{1'b0}}, radix};
    assign rem0    = mag_reg[RW-1:0] - qr_low[RW-1:0];
    assign rem_adj = rem0 - radix;
    assign ge      = (rem0 >= radix);
    assign digit   = ge ? rem_adj[rde_pkg::DIGIT_W-1:0] : rem0[rde_pkg::DIGIT_W-1:0];
    assign q       = q0 + {{(VB-1){1'b0}}, ge};
    assign nd_dec  = nd_reg - rde_pkg::CNT_W'(1);
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg   <= value[VB-1];
            mag_reg   <= value[VB-1] ? (~value + VB'(1)) : value;
            recip_reg <= rde_pkg::recip(radix);
        end else if (cmd.div_step) begin
            mag_reg <= q;
        end
        if (cmd.mul) begin
            prod_reg <= {{VB{1'b0}}, mag_reg} * {{VB{1'b0}}, recip_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_step) begin
            stack_mem[nd_reg[rde_pkg::ADDR_W-1:0]] <= digit;
        end
        if (cmd.rd) begin
            rd_data_reg <= stack_mem[nd_dec[rde_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nd_reg <= '0;
        end else if (cmd.load) begin
            nd_reg <= '0;
        end else if (cmd.div_step) begin
            nd_reg <= nd_reg + rde_pkg::CNT_W'(1);
        end else if (cmd.rd) begin
            nd_reg <= nd_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit_err || cmd.emit_sign || cmd.emit_digit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_err) begin
            char_reg  <= '0;
            last_reg  <= 1'b1;
            error_reg <= 1'b1;
        end else if (cmd.emit_sign) begin
            char_reg  <= rde_pkg::CHAR_MINUS;
            last_reg  <= 1'b0;
            error_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            char_reg  <= rde_pkg::digit_char(alphabet, rd_data_reg);
            last_reg  <= (nd_reg == '0);
            error_reg <= 1'b0;
        end
    end

    assign sts.neg      = neg_reg;
    assign sts.q_zero   = (q == '0);
    assign sts.nd_zero  = (nd_reg == '0);
    assign sts.out_free = out_free;

    assign m_tvalid  = m_tvalid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

`default_nettype wire

### design/signed_radix_digit_emitter_core.sv
// Top level of the signed radix digit emitter: joins configuration, controller and datapath.
// Depends on rde_pkg, rde_config, rde_ctrl and rde_datapath.
//
// Usage. Write the radix (index 0) and the alphabet bytes (indices 1 and 2) through the
// cfg_wr_* port while the block is idle. Each item on the s_ channel is a signed value;
// the m_ channel returns its text form one character per item, most significant digit
// first, preceded by a minus sign for negative values, with m_tlast on the final one.
// An invalid alphabet gives a single item with m_tuser set and m_tlast high.
// Throughput: one value at a time. The divider uses one 32 by 32 reciprocal multiply and
// one correction step per digit, in the MUL and DIV states; the digit stack is then read
// back at one digit per cycle while the receiver does not stall.
// Reset clears the registers to zero, which is an invalid alphabet, and empties the
// output register. When the receiver stalls, the held item stays on m_tdata and the
// block waits; a new value may be taken while the final character still waits.
`timescale 1ns / 1ps
`default_nettype none

module signed_radix_digit_emitter_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rde_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [rde_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rde_pkg::VALUE_BITS-1:0] s_tdata,   // value
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [rde_pkg::CHAR_W-1:0]     m_tdata,   // character
    output logic                                m_tlast,
    output logic                                m_tuser    // error
);

    logic [rde_pkg::RADIX_W-1:0] radix;
    logic [rde_pkg::ALPHA_W-1:0] alphabet;
    logic                        alpha_ok;
    rde_pkg::cmd_t               cmd;
    rde_pkg::sts_t               sts;

    rde_config u_config (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .radix        (radix),
        .alphabet     (alphabet),
        .alpha_ok     (alpha_ok)
    );

    rde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .alpha_ok (alpha_ok),
        .sts      (sts),
        .cmd      (cmd)
    );

    rde_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .value     (s_tdata),
        .radix     (radix),
        .alphabet  (alphabet),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .character (m_tdata),
        .last      (m_tlast),
        .error     (m_tuser)
    );

endmodule

`default_nettype wire

### tb/tb_signed_radix_digit_emitter_core.sv
// Self-checking testbench for signed_radix_digit_emitter_core: a directed part, then
// random alphabets and values, with a scoreboard that predicts each character item.
// Depends on rde_pkg and the design sources; reads no files.
`timescale 1ns / 1ps

module tb_signed_radix_digit_emitter_core;
    import rde_pkg::*;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              err;
    } char_item_t;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    // Holds a copy of the registers and the characters still due from the block.
    class text_scoreboard;
        logic [RADIX_W-1:0] radix;
        logic [ALPHA_W-1:0] alphabet;
        char_item_t         due[$];
        int unsigned        failures;

        function new();
            radix    = '0;
            alphabet = '0;
            failures = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RADIX:      radix = data[RADIX_W-1:0];
                REG_ALPHA_LOW:  alphabet[HALF_W-1:0] = data;
                REG_ALPHA_HIGH: alphabet[ALPHA_W-1:HALF_W] = data;
                default: ;
            endcase
        endfunction

        function bit usable();
            logic [CHAR_W-1:0] c;
            if (radix < 2 || radix > MAX_RADIX) return 1'b0;
            for (int a = 0; a < radix; a++) begin
                c = alphabet[a*CHAR_W +: CHAR_W];
                if (c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
                for (int b = 0; b < a; b++) begin
                    if (alphabet[b*CHAR_W +: CHAR_W] == c) return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_value(input value_t v);
            logic [VALUE_BITS-1:0] mag;
            logic [DIGIT_W-1:0]    digs [0:VALUE_BITS];
            int                    n;
            if (!usable()) begin
                due.push_back('{8'h00, 1'b1, 1'b1});
                return;
            end
            mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
            n = 0;
            do begin
                digs[n] = DIGIT_W'(mag % radix);
                mag = mag / radix;
                n++;
            end while (mag != 0);
            if (v[VALUE_BITS-1]) due.push_back('{CHAR_MINUS, 1'b0, 1'b0});
            for (int i = n - 1; i >= 0; i--) begin
                due.push_back('{alphabet[digs[i]*CHAR_W +: CHAR_W], i == 0, 1'b0});
            end
        endfunction

        function void check_char(input logic [CHAR_W-1:0] ch, input logic last,
                                 input logic err);
            char_item_t want;
            if (due.size() == 0) begin
                $error("character %h arrived with nothing due", ch);
                failures++;
                return;
            end
            want = due.pop_front();
            if (ch !== want.ch) begin
                $error("character: expected %h, got %h", want.ch, ch);
                failures++;
            end
            if (last !== want.last) begin
                $error("last: expected %b, got %b", want.last, last);
                failures++;
            end
            if (err !== want.err) begin
                $error("error: expected %b, got %b", want.err, err);
                failures++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [VALUE_BITS-1:0] s_tdata      = '0;
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [CHAR_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    bit             no_gaps = 1'b0;
    value_t         batch[$];
    text_scoreboard book = new();

    signed_radix_digit_emitter_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            book.check_char(m_tdata, m_tlast, m_tuser);
        end
        m_tready <= no_gaps || ($urandom_range(0, 99) >= 6);
    end

    function automatic logic [ALPHA_W-1:0] text_alphabet(input string s);
        logic [ALPHA_W-1:0] a;
        a = '0;
        for (int i = 0; i < s.len(); i++) a[i*CHAR_W +: CHAR_W] = s[i];
        return a;
    endfunction

    // Characters in use are distinct and never a sign; the unused ones are arbitrary.
    function automatic logic [ALPHA_W-1:0] random_alphabet(input int unsigned r);
        logic [255:0]       used;
        logic [ALPHA_W-1:0] a;
        logic [CHAR_W-1:0]  c;
        used = '0;
        used[CHAR_PLUS]  = 1'b1;
        used[CHAR_MINUS] = 1'b1;
        for (int i = 0; i < MAX_RADIX; i++) begin
            c = CHAR_W'($urandom);
            if (i < r) begin
                while (used[c]) c = CHAR_W'($urandom);
            end
            used[c] = 1'b1;
            a[i*CHAR_W +: CHAR_W] = c;
        end
        return a;
    endfunction

    function automatic value_t random_value(input int unsigned r);
        value_t      v;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            v = $urandom;
        end else if (pick < 85) begin
            v = $urandom_range(0, r * r * r);
            if ($urandom_range(0, 1)) v = -v;
        end else begin
            case ($urandom_range(0, 4))
                0:       v = VALUE_MIN;
                1:       v = VALUE_MAX;
                2:       v = 0;
                3:       v = -1;
                default: v = 1;
            endcase
        end
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        book.set_register(idx, data);
    endtask

    task automatic load_alphabet(input logic [RADIX_W-1:0] r, input logic [ALPHA_W-1:0] a);
        logic [CFG_DATA_W-1:0] rdata;
        rdata = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
        rdata[RADIX_W-1:0] = r;
        write_reg(REG_RADIX, rdata);
        write_reg(REG_ALPHA_LOW, a[HALF_W-1:0]);
        write_reg(REG_ALPHA_HIGH, a[ALPHA_W-1:HALF_W]);
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_value(input value_t v);
        while (!no_gaps && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        book.note_value(v);
    endtask

    // Sends the queued values, then waits until every character has come back.
    task automatic run_batch();
        foreach (batch[i]) send_value(batch[i]);
        s_tvalid <= 1'b0;
        batch.delete();
        while (book.due.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [ALPHA_W-1:0] a;
        logic [ALPHA_W-1:0] hex;
        int unsigned        r;
        int unsigned        count;
        int unsigned        sent;
        int unsigned        i;
        int unsigned        j;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // All registers are zero after reset, which is not a usable alphabet.
        batch = '{value_t'(0), value_t'(-1)};
        run_batch();

        load_alphabet(5'd10, text_alphabet("0123456789"));
        batch = '{value_t'(0), value_t'(1), value_t'(-1), value_t'(9), value_t'(10),
                  value_t'(-10), VALUE_MAX, VALUE_MIN};
        run_batch();

        load_alphabet(5'd2, text_alphabet("01"));
        batch = '{value_t'(0), VALUE_MIN, VALUE_MAX, value_t'(-1)};
        run_batch();

        // Zero and all-ones bytes are ordinary digit characters.
        hex = text_alphabet("0123456789ABCDEF");
        hex[CHAR_W-1:0]              = 8'h00;
        hex[ALPHA_W-1 -: CHAR_W]     = 8'hFF;
        load_alphabet(5'd16, hex);
        batch = '{value_t'(0), value_t'(15), VALUE_MIN};
        run_batch();

        load_alphabet(5'd1, text_alphabet("01"));
        batch = '{value_t'(5)};
        run_batch();
        load_alphabet(5'd31, hex);
        batch = '{value_t'(7)};
        run_batch();
        load_alphabet(5'd17, hex);
        batch = '{value_t'(-7)};
        run_batch();
        load_alphabet(5'd4, text_alphabet("abca"));
        batch = '{value_t'(-3)};
        run_batch();
        load_alphabet(5'd5, text_alphabet("ab+cd"));
        batch = '{value_t'(3)};
        run_batch();
        load_alphabet(5'd3, text_alphabet("x-y"));
        batch = '{value_t'(3)};
        run_batch();
        // Sign characters beyond the radix are not in use and do not matter.
        load_alphabet(5'd3, text_alphabet("abc+-"));
        batch = '{value_t'(-5)};
        run_batch();

        sent = 0;
        for (int phase = 0; sent < 400; phase++) begin
            no_gaps = (phase == 3 || phase == 4);
            case ($urandom_range(0, 3))
                0:       r = 2;
                1:       r = MAX_RADIX;
                default: r = $urandom_range(2, MAX_RADIX);
            endcase
            a = random_alphabet(r);
            count = 32;
            if ($urandom_range(0, 9) >= 8) begin
                count = 4;
                case ($urandom_range(0, 3))
                    0: r = $urandom_range(0, 1);
                    1: r = $urandom_range(MAX_RADIX + 1, 31);
                    2: begin
                        i = $urandom_range(1, r - 1);
                        j = $urandom_range(0, i - 1);
                        a[i*CHAR_W +: CHAR_W] = a[j*CHAR_W +: CHAR_W];
                    end
                    default: begin
                        i = $urandom_range(0, r - 1);
                        a[i*CHAR_W +: CHAR_W] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
                    end
                endcase
            end
            load_alphabet(RADIX_W'(r), a);
            repeat (count) batch.push_back(random_value(r));
            run_batch();
            sent += count;
        end

        no_gaps = 1'b0;
        repeat (40) @(posedge aclk);
        if (book.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
